// ----- sv/fpba_pkg.sv -----
package fpba_pkg;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef struct packed {
		logic        command;
		logic [2:0]  block_index;
		logic [15:0] size_value;
	} request_t;

	typedef struct packed {
		logic        granted;
		logic [2:0]  chosen_block;
		logic [15:0] remaining_size;
	} result_t;

endpackage

// ----- sv/fit_policy_block_allocator.sv -----
// A load request gives no result; busy stays low.
// An allocation request passes through the scan, finish and update states to the done strobe;
// the scan reads the free-size table through its single read port into one compare unit.
// A new request is accepted in the same cycle that done is shown; the receiver cannot stall.
// Asynchronous reset marks every table entry empty (size zero) and selects first fit.
module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = 8,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fpba_pkg::request_t  req,
	output logic                done,
	output fpba_pkg::result_t   rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FINISH = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [1:0]             policy_q;
	logic [NUM_BLOCKS-1:0]  valid_q;
	logic [SIZE_BITS-1:0]   mem [NUM_BLOCKS];
	logic [IDX_W-1:0]       cnt_q;
	logic [SIZE_BITS-1:0]   req_size_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [SIZE_BITS-1:0]   rd_data_s1;
	logic                   ent_vld_s1;
	logic                   found_q;
	logic [SIZE_BITS-1:0]   best_q;
	logic [IDX_W-1:0]       pick_q;
	logic                   done_q;
	fpba_pkg::result_t      rsp_q;

	logic                   accept;
	logic                   load_ok;
	logic [SIZE_BITS-1:0]   in_size;
	logic [SIZE_BITS-1:0]   eff;
	logic                   fits;
	logic                   better;
	logic                   take;
	logic [SIZE_BITS-1:0]   diff;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [SIZE_BITS-1:0]   wr_data;

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign rsp     = rsp_q;
	assign accept  = start && !busy;
	assign in_size = SIZE_BITS'(req.size_value);
	assign load_ok = accept && (req.command == fpba_pkg::CMD_LOAD)
		&& (32'(req.block_index) < NUM_BLOCKS);

	assign eff    = ent_vld_s1 ? rd_data_s1 : '0;
	assign fits   = (eff >= req_size_q);
	assign better = !found_q
		|| ((policy_q == fpba_pkg::POL_BEST) && (eff < best_q))
		|| ((policy_q == fpba_pkg::POL_WORST) && (eff > best_q));
	assign take   = pend_s1 && fits && better;
	assign diff   = best_q - req_size_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = in_size;
		if (load_ok) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(req.block_index);
		end else if ((state_q == ST_UPDATE) && found_q) begin
			wr_en   = 1'b1;
			wr_addr = pick_q;
			wr_data = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[cnt_q];
		ent_vld_s1 <= valid_q[cnt_q];
		idx_s1     <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= fpba_pkg::POL_FIRST;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SCAN);
			done_q  <= 1'b0;
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.command == fpba_pkg::CMD_ALLOC)) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(NUM_BLOCKS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_size_q <= in_size;
		end
		if (take) begin
			best_q <= eff;
			pick_q <= idx_s1;
		end
		if (state_q == ST_UPDATE) begin
			rsp_q.granted        <= found_q;
			rsp_q.chosen_block   <= found_q ? 3'(pick_q) : 3'd0;
			rsp_q.remaining_size <= found_q ? 16'(diff) : 16'd0;
		end
	end

`ifndef SYNTH
	// An allocation keeps the block busy until its result is produced.
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.command == fpba_pkg::CMD_ALLOC) |=> busy)
		else $error("allocation did not raise busy");

	// A load completes at once and never produces a result.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.command == fpba_pkg::CMD_LOAD) |=> !busy && !done)
		else $error("load raised busy or done");

	// A refused allocation reports a zero block index and size.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.granted |-> (rsp.chosen_block == 3'd0) && (rsp.remaining_size == 16'd0))
		else $error("refused allocation carries nonzero fields");

	// Results never come in consecutive cycles.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done asserted twice in a row");
`endif

endmodule
